FILE: rtl/core/ring_segment_mark_run_finder_unit_assert.svh
// Assertion macros for the ring segment mark run finder unit.
// Used by the port checker; depends on nothing else.
`ifndef RING_SEGMENT_MARK_RUN_FINDER_UNIT_ASSERT_SVH
`define RING_SEGMENT_MARK_RUN_FINDER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RSMRF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rsmrf assertion failed");

// Next-cycle implication, disabled during reset.
`define RSMRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rsmrf assertion failed");

`endif

FILE: rtl/core/rsmrf_pkg.sv
// Shared types and codes for the ring segment mark run finder.
// No dependencies; imported by every module of the block.
`default_nettype none

package rsmrf_pkg;

   // Default ring capacity and register reset.
   localparam int MAX_SEGMENTS_DEFAULT = 64;
   localparam int CFG_WIDTH            = 7;
   localparam int REQ_TYPE_WIDTH       = 3;
   localparam int SEG_INDEX_WIDTH      = 6;
   localparam int VERTEX_WIDTH         = 7;
   localparam logic [CFG_WIDTH-1:0] NUM_SEGMENTS_RESET = 7'd64;
   localparam logic [CFG_WIDTH-1:0] NUM_SEGMENTS_MIN   = 7'd3;

   // Request codes.
   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_CLEAR        = 3'd0;
   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_MARK_INVALID = 3'd1;
   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_MARK_MATCHED = 3'd2;
   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_QUERY        = 3'd3;
   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_REPORT       = 3'd4;

   typedef struct packed {
      logic [REQ_TYPE_WIDTH-1:0]  req_type;
      logic [SEG_INDEX_WIDTH-1:0] segment_index;
   } req_item_type;

   typedef struct packed {
      logic                    seg_invalid;
      logic                    seg_known;
      logic                    all_known;
      logic                    all_invalid;
      logic                    any_invalid;
      logic                    run_valid;
      logic [VERTEX_WIDTH-1:0] run_start;
      logic [VERTEX_WIDTH-1:0] run_end;
      logic                    last;
   } rsp_item_type;

   // Command word handed from the front queue to the back end.
   typedef struct packed {
      logic [REQ_TYPE_WIDTH-1:0]  op;
      logic [SEG_INDEX_WIDTH-1:0] segment_index;
   } cmd_type;

endpackage

`default_nettype wire

FILE: rtl/core/ring_segment_mark_run_finder_unit.sv
// Top level of the ring segment mark run finder.
// Depends on rsmrf_pkg, rsmrf_front and rsmrf_back.
`default_nettype none

// Keeps an invalid and a matched mark per ring segment and answers queries
// and run reports. Requests enter a two-word queue, so req_stall rises only
// when two commands are waiting. The back end takes one queued command per
// cycle unless it is walking a run report or a word waits on a stalled output
// register; a query's word lands in the output register. A run report first
// finds the end vertex of the first run, then emits one run per cycle for as
// long as rsp_stall is low (up to MAX_SEGMENTS/2 runs); reports with no runs
// or an all-invalid ring return one word. The ring size write on the csr port
// is always ready and clears all marks; write it only while the block is idle.
module ring_segment_mark_run_finder_unit #(
   parameter int MAX_SEGMENTS = rsmrf_pkg::MAX_SEGMENTS_DEFAULT
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  rsmrf_pkg::req_item_type          req_data,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output rsmrf_pkg::rsp_item_type          rsp_data,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [rsmrf_pkg::CFG_WIDTH-1:0]  csr_wdata
);
   import rsmrf_pkg::*;

   logic    cmd_valid;
   cmd_type cmd_data;
   logic    cmd_pop;

   assign csr_ready = 1'b1;

   // Accept and queue requests.
   rsmrf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop)
   );

   // Execute commands and drive results.
   rsmrf_back #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .csr_write (csr_valid && csr_ready),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: rtl/core/rsmrf_front.sv
// Front end: accepts request words, drops unknown codes, queues the rest.
// Depends on rsmrf_pkg.
`default_nettype none

module rsmrf_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  rsmrf_pkg::req_item_type req_data,
   output logic                   cmd_valid,
   output rsmrf_pkg::cmd_type     cmd_data,
   input  wire                    cmd_pop
);
   import rsmrf_pkg::*;

   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               known_op;
   logic               push;
   logic               pop;

   // Classify: only the five defined codes reach the back end.
   always_comb begin
      case (req_data.req_type)
         REQ_CLEAR, REQ_MARK_INVALID, REQ_MARK_MATCHED, REQ_QUERY, REQ_REPORT: begin
            known_op = 1'b1;
         end
         default: begin
            known_op = 1'b0;
         end
      endcase
   end

   assign req_stall = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall && known_op;
   assign pop       = cmd_pop && cmd_valid;
   assign cmd_valid = (count_ff != '0);
   assign cmd_data  = queue_ff[rd_ptr_ff];

   // Advance pointers and occupancy.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the queued word.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= '{op: req_data.req_type,
                                  segment_index: req_data.segment_index};
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/rsmrf_back.sv
// Back end: owns the mark vectors and the ring size, executes queued
// commands and drives the result register. Depends on rsmrf_pkg.
`default_nettype none

module rsmrf_back #(
   parameter int MAX_SEGMENTS = rsmrf_pkg::MAX_SEGMENTS_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  cmd_valid,
   input  rsmrf_pkg::cmd_type                   cmd_data,
   output logic                                 cmd_pop,
   input  wire                                  csr_write,
   input  wire  [rsmrf_pkg::CFG_WIDTH-1:0]      csr_wdata,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output rsmrf_pkg::rsp_item_type              rsp_data
);
   import rsmrf_pkg::*;

   localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int NW = $clog2(MAX_SEGMENTS + 1);
   localparam int CW = (NW > CFG_WIDTH) ? NW : CFG_WIDTH;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUNS = 1'b1;

   logic [MAX_SEGMENTS-1:0] inv_ff, inv_in;
   logic [MAX_SEGMENTS-1:0] mat_ff, mat_in;
   logic [CFG_WIDTH-1:0]    num_ff, num_in;
   logic                    state_ff, state_in;
   logic [IW-1:0]           cursor_ff, cursor_in;
   logic [IW-1:0]           first_ff, first_in;
   rsp_item_type            rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic [CW-1:0]           cfg_w;
   logic [NW-1:0]           n_eff;
   logic [IW-1:0]           n_last;
   logic [MAX_SEGMENTS-1:0] seg_mask;
   logic [MAX_SEGMENTS-1:0] start_bits;
   logic [MAX_SEGMENTS-1:0] end_bits;
   logic [MAX_SEGMENTS-1:0] after_cursor;
   logic                    inv_wrap;
   logic                    all_known;
   logic                    all_invalid;
   logic                    any_invalid;
   logic                    idx_in_range;
   logic [IW-1:0]           idx_w;
   logic [IW-1:0]           first_end;
   logic [IW-1:0]           run_s;
   logic [IW-1:0]           run_e;
   logic                    out_free;

   // Lowest set bit; zero when the vector is empty.
   function automatic logic [IW-1:0] lowest_set(input logic [MAX_SEGMENTS-1:0] v);
      logic [IW-1:0] r;
      r = '0;
      for (int i = MAX_SEGMENTS - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = IW'(i);
         end
      end
      return r;
   endfunction

   // Saturate the ring size into [3, MAX_SEGMENTS].
   assign cfg_w = CW'(num_ff);
   always_comb begin
      if (cfg_w < CW'(NUM_SEGMENTS_MIN)) begin
         n_eff = NW'(NUM_SEGMENTS_MIN);
      end else if (cfg_w > CW'(MAX_SEGMENTS)) begin
         n_eff = NW'(MAX_SEGMENTS);
      end else begin
         n_eff = NW'(cfg_w);
      end
   end
   assign n_last   = IW'(n_eff - NW'(1));
   assign inv_wrap = inv_ff[n_last];

   // Per-segment run boundaries: a start follows a clean segment, an end
   // vertex is the first clean segment after an invalid one.
   for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_seg
      logic prev_inv;
      if (i == 0) begin : g_first
         assign prev_inv = inv_wrap;
      end else begin : g_rest
         assign prev_inv = inv_ff[i-1];
      end
      assign seg_mask[i]   = (CW'(i) < CW'(n_eff));
      assign start_bits[i] = seg_mask[i] && inv_ff[i] && !prev_inv;
      assign end_bits[i]   = seg_mask[i] && !inv_ff[i] && prev_inv;
      assign after_cursor[i] = (IW'(i) > cursor_ff) && (i < (1 << IW));
   end

   // Ring-wide flags.
   assign all_known   = (((inv_ff | mat_ff) & seg_mask) == seg_mask);
   assign all_invalid = ((inv_ff & seg_mask) == seg_mask);
   assign any_invalid = |inv_ff;

   assign idx_w        = IW'(cmd_data.segment_index);
   assign idx_in_range = (CW'(cmd_data.segment_index) < CW'(n_eff));

   // The last run reported ends at the end of the run that holds the lowest
   // invalid segment: the lowest end vertex above zero, else vertex zero.
   assign first_end = lowest_set(end_bits & ~MAX_SEGMENTS'(1));

   // Next run after the cursor, wrapping.
   assign run_s = (|(start_bits & after_cursor)) ? lowest_set(start_bits & after_cursor)
                                                  : lowest_set(start_bits);
   assign run_e = (|(end_bits & after_cursor)) ? lowest_set(end_bits & after_cursor)
                                                : lowest_set(end_bits);

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Command execution.
   always_comb begin
      inv_in       = inv_ff;
      mat_in       = mat_ff;
      num_in       = num_ff;
      state_in     = state_ff;
      cursor_in    = cursor_ff;
      first_in     = first_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd_pop      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd_data.op)
                  REQ_CLEAR: begin
                     inv_in  = '0;
                     mat_in  = '0;
                     cmd_pop = 1'b1;
                  end
                  REQ_MARK_INVALID: begin
                     if (idx_in_range) begin
                        inv_in[idx_w] = 1'b1;
                     end
                     cmd_pop = 1'b1;
                  end
                  REQ_MARK_MATCHED: begin
                     if (idx_in_range) begin
                        mat_in[idx_w] = 1'b1;
                     end
                     cmd_pop = 1'b1;
                  end
                  REQ_QUERY: begin
                     if (out_free) begin
                        cmd_pop             = 1'b1;
                        rsp_valid_in        = 1'b1;
                        rsp_in              = '0;
                        rsp_in.seg_invalid  = idx_in_range && inv_ff[idx_w];
                        rsp_in.seg_known    = idx_in_range && (inv_ff[idx_w] || mat_ff[idx_w]);
                        rsp_in.all_known    = all_known;
                        rsp_in.all_invalid  = all_invalid;
                        rsp_in.any_invalid  = any_invalid;
                        rsp_in.last         = 1'b1;
                     end
                  end
                  REQ_REPORT: begin
                     if (any_invalid && !all_invalid) begin
                        // Hand over to the run walk.
                        cmd_pop   = 1'b1;
                        state_in  = ST_RUNS;
                        cursor_in = first_end;
                        first_in  = first_end;
                     end else if (out_free) begin
                        cmd_pop            = 1'b1;
                        rsp_valid_in       = 1'b1;
                        rsp_in             = '0;
                        rsp_in.all_known   = all_known;
                        rsp_in.all_invalid = all_invalid;
                        rsp_in.any_invalid = any_invalid;
                        rsp_in.run_valid   = any_invalid;
                        rsp_in.run_end     = any_invalid ? VERTEX_WIDTH'(n_eff)
                                                         : '0;
                        rsp_in.last        = 1'b1;
                     end
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_RUNS: begin
            // Emit one run per free output slot.
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in             = '0;
               rsp_in.all_known   = all_known;
               rsp_in.any_invalid = 1'b1;
               rsp_in.run_valid   = 1'b1;
               rsp_in.run_start   = VERTEX_WIDTH'(run_s);
               rsp_in.run_end     = VERTEX_WIDTH'(run_e);
               rsp_in.last        = (run_e == first_ff);
               cursor_in          = run_e;
               if (run_e == first_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Ring size write drops all marks.
      if (csr_write) begin
         num_in = csr_wdata;
         inv_in = '0;
         mat_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff       <= '0;
         mat_ff       <= '0;
         num_ff       <= NUM_SEGMENTS_RESET;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         inv_ff       <= inv_in;
         mat_ff       <= mat_in;
         num_ff       <= num_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cursor_ff <= cursor_in;
      first_ff  <= first_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

FILE: rtl/core/rsmrf_checker.sv
// Port checker for the ring segment mark run finder, bound to the top level.
// Depends on rsmrf_pkg and ring_segment_mark_run_finder_unit_assert.svh.
`default_nettype none

`include "ring_segment_mark_run_finder_unit_assert.svh"

module rsmrf_checker (
   input wire                     clock,
   input wire                     reset,
   input wire                     rsp_valid,
   input wire                     rsp_stall,
   input rsmrf_pkg::rsp_item_type rsp_data
);
   import rsmrf_pkg::*;

   // Hold a stalled result word.
   `RSMRF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // A word without a run always closes its request.
   `RSMRF_ASSERT_NOW(a_norun_last, clock, reset, rsp_valid && !rsp_data.run_valid, rsp_data.last)

   // Run words carry no segment flags and imply some invalid segment.
   `RSMRF_ASSERT_NOW(a_run_flags, clock, reset, rsp_valid && rsp_data.run_valid, !rsp_data.seg_invalid && !rsp_data.seg_known && rsp_data.any_invalid)

   // A fully invalid ring is known and has an invalid segment.
   `RSMRF_ASSERT_NOW(a_all_invalid, clock, reset, rsp_valid && rsp_data.all_invalid, rsp_data.any_invalid && rsp_data.all_known)

endmodule

bind ring_segment_mark_run_finder_unit rsmrf_checker u_rsmrf_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench for ring_segment_mark_run_finder_unit: a directed table, then random words,
// each answer checked against a typed row or a mark predictor. Depends on rsmrf_pkg.
module tb_top;
   import rsmrf_pkg::*;

   localparam int DRAIN_CYCLES  = 8;
   localparam int TAIL_CYCLES   = 40;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int MAX_RUNS      = MAX_SEGMENTS_DEFAULT / 2;
   localparam int PHASE_WORDS   = 40;
   localparam int NUM_PHASES    = 10;
   localparam int QUIET_PHASE   = 3;
   localparam int IDLE_PCT      = 34;
   localparam int ERR_PRINT_CAP = 100;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      req_item_type word;
      bit           typed;
      rsp_item_type answer;
   } stim_row_type;

   // Typed answers that follow directly from the flags.
   localparam rsp_item_type EMPTY_RING =
      rsp_item_type'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 7'd0, 1'b1};
   localparam rsp_item_type FULL_RING_RUN =
      rsp_item_type'{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 7'd0, 7'd3, 1'b1};
   localparam rsp_item_type FULL_RING_QUERY =
      rsp_item_type'{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 7'd0, 7'd0, 1'b1};
   localparam rsp_item_type NO_ANSWER = '0;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_item_type         req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_item_type         rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CFG_WIDTH-1:0] csr_wdata = '0;

   // Predictor state: marks and the raw ring size register.
   logic [MAX_SEGMENTS_DEFAULT-1:0] inv_marks     = '0;
   logic [MAX_SEGMENTS_DEFAULT-1:0] mat_marks     = '0;
   logic [CFG_WIDTH-1:0]            ring_size_reg = NUM_SEGMENTS_RESET;
   rsp_item_type                    ring_answers_q[$];
   stim_row_type                    stim_table[$];

   int          mismatch_count = 0;
   int          idle_pct       = IDLE_PCT;
   int          words_sent     = 0;
   int unsigned cycle_count    = 0;

   ring_segment_mark_run_finder_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Saturate the register to the legal ring size.
   function automatic int unsigned ring_segments();
      if (ring_size_reg < NUM_SEGMENTS_MIN) return NUM_SEGMENTS_MIN;
      if (ring_size_reg > MAX_SEGMENTS_DEFAULT) return MAX_SEGMENTS_DEFAULT;
      return ring_size_reg;
   endfunction

   function automatic int unsigned next_segment(int unsigned i, int unsigned n);
      return (i + 1 >= n) ? 0 : i + 1;
   endfunction

   task automatic report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= ERR_PRINT_CAP)
         $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   task automatic check_field(string name, logic [VERTEX_WIDTH-1:0] got,
                              logic [VERTEX_WIDTH-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   // Append one expected result word at the tail of the pending list.
   task automatic enqueue_answer(rsp_item_type a);
      ring_answers_q.insert(ring_answers_q.size(), a);
   endtask

   // Update the marks for one accepted word and queue the answers it causes.
   task automatic apply_to_ring_marks(req_item_type w, bit keep_answer);
      int unsigned  n, idx, i, s, e, first_end, guard, k;
      logic         known_all, inv_all, inv_any;
      rsp_item_type ans;
      n = ring_segments();
      idx = int'(w.segment_index);
      known_all = 1'b1;
      inv_all = 1'b1;
      inv_any = 1'b0;
      for (i = 0; i < n; i++) begin
         if (!(inv_marks[i] || mat_marks[i])) known_all = 1'b0;
         if (inv_marks[i]) inv_any = 1'b1;
         else inv_all = 1'b0;
      end
      ans = '0;
      ans.all_known = known_all;
      ans.all_invalid = inv_all;
      ans.any_invalid = inv_any;
      ans.last = 1'b1;
      case (w.req_type)
         REQ_CLEAR: begin
            inv_marks = '0;
            mat_marks = '0;
         end
         REQ_MARK_INVALID: if (idx < n) inv_marks[idx] = 1'b1;
         REQ_MARK_MATCHED: if (idx < n) mat_marks[idx] = 1'b1;
         REQ_QUERY: begin
            if (idx < n) begin
               ans.seg_invalid = inv_marks[idx];
               ans.seg_known = inv_marks[idx] | mat_marks[idx];
            end
            if (keep_answer) enqueue_answer(ans);
         end
         REQ_REPORT: begin
            if (!inv_any || inv_all) begin
               // No run at all, or the whole ring as one run.
               ans.run_valid = inv_all;
               ans.run_end = inv_all ? VERTEX_WIDTH'(n) : '0;
               if (keep_answer) enqueue_answer(ans);
            end else begin
               // Skip past the first run; it is reported last.
               s = 0;
               while (!inv_marks[s]) s = next_segment(s, n);
               e = next_segment(s, n);
               while (inv_marks[e]) e = next_segment(e, n);
               first_end = e;
               k = 0;
               for (guard = 0; guard < n && k < MAX_RUNS; guard++) begin
                  s = e;
                  while (!inv_marks[s]) s = next_segment(s, n);
                  e = next_segment(s, n);
                  while (inv_marks[e]) e = next_segment(e, n);
                  ans.run_valid = 1'b1;
                  ans.run_start = VERTEX_WIDTH'(s);
                  ans.run_end = VERTEX_WIDTH'(e);
                  ans.last = (e == first_end);
                  if (keep_answer) enqueue_answer(ans);
                  k++;
                  if (e == first_end) break;
               end
            end
         end
         default: ;
      endcase
   endtask

   // Present one word after a random gap, hold it until taken, then predict.
   task automatic send_word(req_item_type w, bit typed, rsp_item_type answer);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      apply_to_ring_marks(w, !typed);
      if (typed) enqueue_answer(answer);
   endtask

   // Drain the block, then write the ring size; the write clears all marks.
   task automatic write_ring_size(logic [CFG_WIDTH-1:0] value);
      req_valid <= 1'b0;
      while (ring_answers_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      ring_size_reg = value;
      inv_marks = '0;
      mat_marks = '0;
   endtask

   task automatic add_row(row_kind_type kind, logic [REQ_TYPE_WIDTH-1:0] code, int unsigned arg,
                          bit typed, rsp_item_type answer);
      stim_row_type row;
      row.kind = kind;
      row.word.req_type = code;
      row.word.segment_index = SEG_INDEX_WIDTH'(arg);
      row.typed = typed;
      row.answer = answer;
      if (kind == ROW_CSR) row.word.segment_index = '0;
      if (kind == ROW_CSR) row.answer.run_start = VERTEX_WIDTH'(arg);
      stim_table.insert(stim_table.size(), row);
   endtask

   function automatic req_item_type pick_word(int unsigned n);
      req_item_type w;
      int unsigned  r;
      r = $urandom_range(99);
      if ($urandom_range(99) < 85) w.segment_index = SEG_INDEX_WIDTH'($urandom_range(n - 1));
      else w.segment_index = SEG_INDEX_WIDTH'($urandom_range(63));
      if (r < 33) w.req_type = REQ_MARK_INVALID;
      else if (r < 55) w.req_type = REQ_MARK_MATCHED;
      else if (r < 75) w.req_type = REQ_QUERY;
      else if (r < 89) w.req_type = REQ_REPORT;
      else if (r < 94) w.req_type = REQ_CLEAR;
      else w.req_type = REQ_REPORT + REQ_TYPE_WIDTH'($urandom_range(3, 1));
      return w;
   endfunction

   // Mark every segment at a chosen density, then ask for the runs.
   task automatic sweep_ring();
      int unsigned  n, density, seg;
      req_item_type w;
      n = ring_segments();
      case ($urandom_range(3))
         0: density = 40;
         1: density = 75;
         2: density = 95;
         default: density = 100;
      endcase
      for (seg = 0; seg < n; seg++) begin
         w.req_type = ($urandom_range(99) < density) ? REQ_MARK_INVALID : REQ_MARK_MATCHED;
         w.segment_index = SEG_INDEX_WIDTH'(seg);
         send_word(w, 1'b0, NO_ANSWER);
      end
      w.req_type = REQ_REPORT;
      w.segment_index = SEG_INDEX_WIDTH'($urandom_range(63));
      send_word(w, 1'b0, NO_ANSWER);
   endtask

   // Check each accepted result word against the oldest pending answer.
   always @(posedge clock) begin : rsp_check
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (ring_answers_q.size() == 0) begin
            report_mismatch($sformatf("result word %h with nothing pending", rsp_data));
         end else begin
            want = ring_answers_q.pop_front();
            check_field("seg_invalid", 7'(rsp_data.seg_invalid), 7'(want.seg_invalid));
            check_field("seg_known", 7'(rsp_data.seg_known), 7'(want.seg_known));
            check_field("all_known", 7'(rsp_data.all_known), 7'(want.all_known));
            check_field("all_invalid", 7'(rsp_data.all_invalid), 7'(want.all_invalid));
            check_field("any_invalid", 7'(rsp_data.any_invalid), 7'(want.any_invalid));
            check_field("run_valid", 7'(rsp_data.run_valid), 7'(want.run_valid));
            check_field("run_start", rsp_data.run_start, want.run_start);
            check_field("run_end", rsp_data.run_end, want.run_end);
            check_field("last", 7'(rsp_data.last), 7'(want.last));
         end
      end
      rsp_stall <= ($urandom_range(99) < idle_pct);
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("ring_segment_mark_run_finder_unit verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      logic [CFG_WIDTH-1:0] ring_values[NUM_PHASES];
      int                   phase, goal;
      ring_values = '{7'd3, 7'd127, 7'd2, 7'd64, 7'd1, 7'd0, 7'd65, 7'd5, 7'd17, 7'd0};
      ring_values[5] = CFG_WIDTH'($urandom_range(127));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part: fresh ring, wrap run, unknown codes, small full ring.
      add_row(ROW_REQ, REQ_QUERY, 0, 1'b1, EMPTY_RING);
      add_row(ROW_REQ, REQ_REPORT, 0, 1'b1, EMPTY_RING);
      add_row(ROW_REQ, REQ_MARK_INVALID, 0, 1'b0, NO_ANSWER);
      add_row(ROW_REQ, REQ_MARK_INVALID, 63, 1'b0, NO_ANSWER);
      add_row(ROW_REQ, REQ_MARK_MATCHED, 1, 1'b0, NO_ANSWER);
      add_row(ROW_REQ, REQ_REPORT, 0, 1'b0, NO_ANSWER);
      add_row(ROW_REQ, REQ_QUERY, 63, 1'b0, NO_ANSWER);
      add_row(ROW_REQ, REQ_QUERY, 1, 1'b0, NO_ANSWER);
      add_row(ROW_REQ, REQ_REPORT + 3'd1, 63, 1'b0, NO_ANSWER);
      add_row(ROW_REQ, REQ_REPORT + 3'd2, 0, 1'b0, NO_ANSWER);
      add_row(ROW_REQ, REQ_REPORT + 3'd3, 42, 1'b0, NO_ANSWER);
      add_row(ROW_REQ, REQ_MARK_INVALID, 10, 1'b0, NO_ANSWER);
      add_row(ROW_REQ, REQ_MARK_INVALID, 11, 1'b0, NO_ANSWER);
      add_row(ROW_REQ, REQ_REPORT, 0, 1'b0, NO_ANSWER);
      add_row(ROW_REQ, REQ_CLEAR, 63, 1'b0, NO_ANSWER);
      add_row(ROW_REQ, REQ_QUERY, 63, 1'b1, EMPTY_RING);
      add_row(ROW_CSR, REQ_CLEAR, 0, 1'b0, NO_ANSWER);
      add_row(ROW_REQ, REQ_MARK_INVALID, 63, 1'b0, NO_ANSWER);
      add_row(ROW_REQ, REQ_MARK_MATCHED, 5, 1'b0, NO_ANSWER);
      add_row(ROW_REQ, REQ_MARK_INVALID, 0, 1'b0, NO_ANSWER);
      add_row(ROW_REQ, REQ_MARK_INVALID, 1, 1'b0, NO_ANSWER);
      add_row(ROW_REQ, REQ_MARK_INVALID, 2, 1'b0, NO_ANSWER);
      add_row(ROW_REQ, REQ_REPORT, 0, 1'b1, FULL_RING_RUN);
      add_row(ROW_REQ, REQ_QUERY, 63, 1'b1, FULL_RING_QUERY);
      add_row(ROW_REQ, REQ_MARK_MATCHED, 2, 1'b0, NO_ANSWER);
      add_row(ROW_REQ, REQ_QUERY, 2, 1'b0, NO_ANSWER);

      foreach (stim_table[i]) begin
         if (stim_table[i].kind == ROW_CSR)
            write_ring_size(stim_table[i].answer.run_start);
         else
            send_word(stim_table[i].word, stim_table[i].typed, stim_table[i].answer);
      end

      // Random part: one ring size per phase, one phase without idling.
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         idle_pct = (phase == QUIET_PHASE) ? 0 : IDLE_PCT;
         write_ring_size(ring_values[phase]);
         goal = words_sent + PHASE_WORDS;
         while (words_sent < goal) begin
            if ($urandom_range(99) < 4) sweep_ring();
            else send_word(pick_word(ring_segments()), 1'b0, NO_ANSWER);
         end
      end

      // Wait out the remaining answers, then a short tail.
      req_valid <= 1'b0;
      while (ring_answers_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ring_segment_mark_run_finder_unit verification clean");
      end else begin
         $display("ring_segment_mark_run_finder_unit verification failed");
      end
      $finish;
   end

endmodule
